// ===== src/sctd_pkg.sv =====
// ----------------------------------------------------------------------------
// sctd_pkg
// Shared types and constants of the start-code splitter and telemetry deframer.
// ----------------------------------------------------------------------------
package sctd_pkg;

    localparam int PAYLOAD_BYTES = 45;
    localparam int CHAIN_CELLS   = PAYLOAD_BYTES - 1;
    localparam int FILL_W        = 6;

    localparam logic [23:0] START_CODE = 24'h000001;
    localparam int          ROUTE_BIT  = 7;

    localparam int POS_TYPE      = 0;
    localparam int POS_COUNTER   = 7;
    localparam int POS_VALUE     = 13;
    localparam int POS_TIME_LOW  = 29;
    localparam int POS_TIME_HIGH = 33;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = QPTR_W + 1;

    typedef enum logic [1:0] {
        KIND_VIDEO      = 2'd0,
        KIND_RECORD     = 2'd1,
        KIND_MISALIGNED = 2'd2,
        KIND_INCOMPLETE = 2'd3
    } kind_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  video_byte;
        logic        unit_start;
        logic [7:0]  rec_type;
        logic [7:0]  rec_counter;
        logic [31:0] rec_value;
        logic [31:0] rec_time_low;
        logic [31:0] rec_time_high;
        logic        last;
    } result_t;

    typedef logic [7:0] chain_t [CHAIN_CELLS];

    // Payload byte pos sits in cell CHAIN_CELLS-1-pos while the final byte arrives
    function automatic logic [7:0] payload_at(chain_t chain, int pos);
        return chain[CHAIN_CELLS - 1 - pos];
    endfunction

    function automatic logic [31:0] word_at(chain_t chain, int pos);
        return {payload_at(chain, pos + 3), payload_at(chain, pos + 2),
                payload_at(chain, pos + 1), payload_at(chain, pos)};
    endfunction

endpackage

// ===== src/sctd_cell.sv =====
// ----------------------------------------------------------------------------
// sctd_cell
// One byte cell of the payload chain; takes its neighbor's byte on shift.
// ----------------------------------------------------------------------------
module sctd_cell (
    input  logic       clk,
    input  logic       shift_en,
    input  logic [7:0] d,
    output logic [7:0] q
);

    logic [7:0] byte_reg;
    logic [7:0] byte_next;

    always_comb
    begin
        byte_next = shift_en ? d : byte_reg;
    end

    always_ff @(posedge clk)
    begin
        byte_reg <= byte_next;
    end

    assign q = byte_reg;

endmodule

// ===== src/sctd_rqueue.sv =====
// ----------------------------------------------------------------------------
// sctd_rqueue
// Result queue: takes up to two words per cycle, hands out one unless the head is stalled.
// ----------------------------------------------------------------------------
module sctd_rqueue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [1:0]        push_cnt,
    input  sctd_pkg::result_t push0,
    input  sctd_pkg::result_t push1,
    output logic              full,
    output logic              head_valid,
    input  logic              head_stall,
    output sctd_pkg::result_t head
);

    sctd_pkg::result_t mem [sctd_pkg::QDEPTH];

    logic [sctd_pkg::QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [sctd_pkg::QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [sctd_pkg::QCNT_W-1:0] count_reg, count_next;
    logic                        pop;

    assign head_valid = (count_reg != '0);
    assign pop        = head_valid && !head_stall;
    assign full       = count_reg > sctd_pkg::QCNT_W'(sctd_pkg::QDEPTH - 2);
    assign head       = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + sctd_pkg::QPTR_W'(push_cnt);
        rd_ptr_next = rd_ptr_reg + sctd_pkg::QPTR_W'(pop);
        count_next  = count_reg + sctd_pkg::QCNT_W'(push_cnt) - sctd_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_cnt != 2'd0)
        begin
            mem[wr_ptr_reg] <= push0;
        end
        if (push_cnt == 2'd2)
        begin
            mem[wr_ptr_reg + sctd_pkg::QPTR_W'(1)] <= push1;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= sctd_pkg::QCNT_W'(sctd_pkg::QDEPTH))
        else $error("result queue count out of range");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push_cnt != 2'd0 |->
        ({1'b0, count_reg} + (sctd_pkg::QCNT_W + 1)'(push_cnt)
         - (sctd_pkg::QCNT_W + 1)'(pop)) <= (sctd_pkg::QCNT_W + 1)'(sctd_pkg::QDEPTH))
        else $error("result queue overflow");

endmodule

// ===== src/start_code_splitter_telemetry_deframer_unit.sv =====
// ----------------------------------------------------------------------------
// start_code_splitter_telemetry_deframer_unit
// Splits a byte stream at 00 00 01 start codes into video and telemetry.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock and gives its results one per clock through
// a four-word result queue; a byte is held off only while the queue has less
// than two free words, so with the result side open the block runs at one
// byte per cycle. The byte after a start code picks the route (bit 7 set for
// telemetry). Telemetry bytes shift through a chain of 44 byte cells; the
// 45th byte of a payload decodes the record or flags misalignment in the same
// cycle. A start code inside a partial payload gives an incomplete error
// word ahead of the byte's own result, if that byte gives one.
module start_code_splitter_telemetry_deframer_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        data_valid,
    output logic        data_stall,
    input  logic [7:0]  data_byte,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  kind,
    output logic [7:0]  video_byte,
    output logic        unit_start,
    output logic [7:0]  rec_type,
    output logic [7:0]  rec_counter,
    output logic [31:0] rec_value,
    output logic [31:0] rec_time_low,
    output logic [31:0] rec_time_high,
    output logic        last
);

    logic [23:0]                 recent_reg, recent_next;
    logic                        tele_reg, tele_next;
    logic [sctd_pkg::FILL_W-1:0] fill_reg, fill_next;

    sctd_pkg::chain_t  chain;
    logic              accept;
    logic              start;
    logic              route;
    logic              incomplete;
    logic              done;
    logic              has_main;
    logic              aligned;
    logic              shift_en;
    logic [sctd_pkg::FILL_W-1:0] fill_base;
    logic [1:0]        push_cnt;
    logic              q_full;
    sctd_pkg::result_t main_res;
    sctd_pkg::result_t inc_res;
    sctd_pkg::result_t push0;
    sctd_pkg::result_t head;

    assign accept     = data_valid && !data_stall;
    assign data_stall = q_full;

    always_comb
    begin
        start      = (recent_reg == sctd_pkg::START_CODE);
        route      = start ? data_byte[sctd_pkg::ROUTE_BIT] : tele_reg;
        fill_base  = start ? '0 : fill_reg;
        incomplete = start && tele_reg && (fill_reg != '0);
        done       = route && (fill_base == sctd_pkg::FILL_W'(sctd_pkg::PAYLOAD_BYTES - 1));
        has_main   = !route || done;
        aligned    = (chain[1] == 8'h00) && (chain[0] == 8'h00) && (data_byte == 8'h01);
        shift_en   = accept && route;

        main_res      = '0;
        main_res.last = 1'b1;
        if (!route)
        begin
            main_res.kind       = sctd_pkg::KIND_VIDEO;
            main_res.video_byte = data_byte;
            main_res.unit_start = start;
        end
        else if (aligned)
        begin
            main_res.kind          = sctd_pkg::KIND_RECORD;
            main_res.rec_type      = sctd_pkg::payload_at(chain, sctd_pkg::POS_TYPE);
            main_res.rec_counter   = sctd_pkg::payload_at(chain, sctd_pkg::POS_COUNTER);
            main_res.rec_value     = sctd_pkg::word_at(chain, sctd_pkg::POS_VALUE);
            main_res.rec_time_low  = sctd_pkg::word_at(chain, sctd_pkg::POS_TIME_LOW);
            main_res.rec_time_high = sctd_pkg::word_at(chain, sctd_pkg::POS_TIME_HIGH);
        end
        else
        begin
            main_res.kind = sctd_pkg::KIND_MISALIGNED;
        end

        inc_res      = '0;
        inc_res.kind = sctd_pkg::KIND_INCOMPLETE;
        inc_res.last = !has_main;

        push0 = incomplete ? inc_res : main_res;

        if (accept)
        begin
            push_cnt = 2'(incomplete) + 2'(has_main);
        end
        else
        begin
            push_cnt = 2'd0;
        end

        recent_next = recent_reg;
        tele_next   = tele_reg;
        fill_next   = fill_reg;
        if (accept)
        begin
            recent_next = {recent_reg[15:0], data_byte};
            tele_next   = route;
            if (!route)
            begin
                fill_next = fill_base;
            end
            else if (done)
            begin
                fill_next = '0;
            end
            else
            begin
                fill_next = fill_base + sctd_pkg::FILL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            recent_reg <= '0;
            tele_reg   <= 1'b0;
            fill_reg   <= '0;
        end
        else
        begin
            recent_reg <= recent_next;
            tele_reg   <= tele_next;
            fill_reg   <= fill_next;
        end
    end

    for (genvar i = 0; i < sctd_pkg::CHAIN_CELLS; i++)
    begin : g_cell
        if (i == 0)
        begin : g_head
            sctd_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (data_byte),
                .q        (chain[i])
            );
        end
        else
        begin : g_body
            sctd_cell u_cell (
                .clk      (clk),
                .shift_en (shift_en),
                .d        (chain[i-1]),
                .q        (chain[i])
            );
        end
    end

    sctd_rqueue u_rqueue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_cnt   (push_cnt),
        .push0      (push0),
        .push1      (main_res),
        .full       (q_full),
        .head_valid (result_valid),
        .head_stall (result_stall),
        .head       (head)
    );

    assign kind          = head.kind;
    assign video_byte    = head.video_byte;
    assign unit_start    = head.unit_start;
    assign rec_type      = head.rec_type;
    assign rec_counter   = head.rec_counter;
    assign rec_value     = head.rec_value;
    assign rec_time_low  = head.rec_time_low;
    assign rec_time_high = head.rec_time_high;
    assign last          = head.last;

    a_fill_range: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg < sctd_pkg::FILL_W'(sctd_pkg::PAYLOAD_BYTES))
        else $error("fill index out of range");

    a_start_restarts: assert property (@(posedge clk) disable iff (!rst_n)
        accept && start |=> fill_reg <= sctd_pkg::FILL_W'(1))
        else $error("start code did not restart payload fill");

endmodule
